### rtl/core/integer_to_ascii_formatter_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the integer to ASCII formatter
// Concurrent checks that are compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_FORMATTER_TOP_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define ITOA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ITOA_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ITOA_ASSERT(lbl, clk, rst_n, prop, msg)
`define ITOA_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

### rtl/core/itoa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer to ASCII formatter package
// Beat types, mode codes, controller states and character helpers.
// ----------------------------------------------------------------------------
package itoa_pkg;

  localparam int PtrBits = 64;
  localparam logic [63:0] PtrMask =
    (PtrBits >= 64) ? {64{1'b1}} : ((64'd1 << PtrBits) - 64'd1);

  localparam int DecBits   = 32;
  localparam int StepWidth = $clog2(DecBits);
  localparam int BcdDigits = 10;
  localparam int BcdBits   = 4 * BcdDigits;
  localparam int NumNibs   = 16;
  localparam int PosWidth  = $clog2(NumNibs);

  localparam logic [30:0] TotalMax = {31{1'b1}};

  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharX     = 8'h78;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharUpA   = 8'h41;

  typedef enum logic [2:0] {
    MODE_SDEC = 3'd0,
    MODE_UDEC = 3'd1,
    MODE_PTR  = 3'd2,
    MODE_HEXL = 3'd3,
    MODE_HEXU = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    SEL_MINUS,
    SEL_ZERO,
    SEL_X,
    SEL_DIGIT
  } char_sel_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_LEAD,
    ST_MINUS,
    ST_PFX0,
    ST_PFXX,
    ST_DIGITS
  } state_e;

  typedef struct packed {
    logic [2:0]  mode;
    logic [63:0] operand_value;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  out_char;
    logic        last_char;
    logic [30:0] count_after;
  } out_beat_t;

  typedef struct packed {
    logic      load;
    logic      conv_step;
    logic      lead;
    logic      emit;
    char_sel_e sel;
    logic      last;
  } cmd_t;

  typedef struct packed {
    logic is_ptr;
    logic neg;
    logic step_last;
    logic pos_zero;
    logic out_free;
  } sts_t;

  function automatic logic [7:0] digit_char(input logic [3:0] nib, input logic upper);
    logic [7:0] base;
    base = upper ? CharUpA : CharLowA;
    if (nib < 4'd10) begin
      digit_char = CharZero + {4'd0, nib};
    end else begin
      digit_char = base + {4'd0, nib - 4'd10};
    end
  endfunction

endpackage

### rtl/core/itoa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer to ASCII formatter controller
// Sequences loading, decimal conversion, leading digit search and emission.
// ----------------------------------------------------------------------------
module itoa_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [2:0]      mode_i,
  output logic            in_ready_o,
  input  itoa_pkg::sts_t  sts_i,
  output itoa_pkg::cmd_t  cmd_o
);

  itoa_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= itoa_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      itoa_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          unique case (mode_i) inside
            itoa_pkg::MODE_SDEC, itoa_pkg::MODE_UDEC: state_d = itoa_pkg::ST_CONV;
            itoa_pkg::MODE_PTR, itoa_pkg::MODE_HEXL, itoa_pkg::MODE_HEXU:
              state_d = itoa_pkg::ST_LEAD;
            default: state_d = itoa_pkg::ST_IDLE;
          endcase
        end
      end
      itoa_pkg::ST_CONV: begin
        if (sts_i.step_last) state_d = itoa_pkg::ST_LEAD;
      end
      itoa_pkg::ST_LEAD: begin
        if (sts_i.neg) begin
          state_d = itoa_pkg::ST_MINUS;
        end else if (sts_i.is_ptr) begin
          state_d = itoa_pkg::ST_PFX0;
        end else begin
          state_d = itoa_pkg::ST_DIGITS;
        end
      end
      itoa_pkg::ST_MINUS: begin
        if (sts_i.out_free) state_d = itoa_pkg::ST_DIGITS;
      end
      itoa_pkg::ST_PFX0: begin
        if (sts_i.out_free) state_d = itoa_pkg::ST_PFXX;
      end
      itoa_pkg::ST_PFXX: begin
        if (sts_i.out_free) state_d = itoa_pkg::ST_DIGITS;
      end
      itoa_pkg::ST_DIGITS: begin
        if (sts_i.out_free && sts_i.pos_zero) state_d = itoa_pkg::ST_IDLE;
      end
      default: state_d = itoa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o      = 1'b0;
    cmd_o           = '0;
    cmd_o.sel       = itoa_pkg::SEL_DIGIT;
    unique case (state_q)
      itoa_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      itoa_pkg::ST_CONV: cmd_o.conv_step = 1'b1;
      itoa_pkg::ST_LEAD: cmd_o.lead = 1'b1;
      itoa_pkg::ST_MINUS: begin
        cmd_o.emit = sts_i.out_free;
        cmd_o.sel  = itoa_pkg::SEL_MINUS;
      end
      itoa_pkg::ST_PFX0: begin
        cmd_o.emit = sts_i.out_free;
        cmd_o.sel  = itoa_pkg::SEL_ZERO;
      end
      itoa_pkg::ST_PFXX: begin
        cmd_o.emit = sts_i.out_free;
        cmd_o.sel  = itoa_pkg::SEL_X;
      end
      itoa_pkg::ST_DIGITS: begin
        cmd_o.emit = sts_i.out_free;
        cmd_o.sel  = itoa_pkg::SEL_DIGIT;
        cmd_o.last = sts_i.pos_zero;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

### rtl/core/itoa_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer to ASCII formatter datapath
// Shift-add-3 decimal conversion, digit register, output stage and total.
// ----------------------------------------------------------------------------
module itoa_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  itoa_pkg::in_beat_t  in_data_i,
  input  itoa_pkg::cmd_t      cmd_i,
  output itoa_pkg::sts_t      sts_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output itoa_pkg::out_beat_t out_data_o
);

  logic [2:0]                      mode_q, mode_d;
  logic                            neg_q, neg_d;
  logic [itoa_pkg::DecBits-1:0]    bin_q, bin_d;
  logic [4*itoa_pkg::NumNibs-1:0]  dig_q, dig_d;
  logic [itoa_pkg::StepWidth-1:0]  step_q, step_d;
  logic [itoa_pkg::PosWidth-1:0]   pos_q, pos_d;
  logic                            out_valid_q, out_valid_d;
  itoa_pkg::out_beat_t             out_data_q, out_data_d;
  logic [30:0]                     total_q, total_d;

  logic [31:0]                     low;
  logic                            low_neg;
  logic [itoa_pkg::BcdBits-1:0]    bcd_adj;
  logic [itoa_pkg::PosWidth-1:0]   lead_pos;
  logic [3:0]                      cur_nib;
  logic [7:0]                      cur_char;
  logic [30:0]                     total_inc;
  logic                            out_free;

  assign low      = in_data_i.operand_value[31:0];
  assign low_neg  = (in_data_i.mode == itoa_pkg::MODE_SDEC) && low[31];
  assign out_free = !out_valid_q || out_ready_i;
  assign cur_nib  = dig_q[{pos_q, 2'b00} +: 4];
  assign total_inc = (total_q == itoa_pkg::TotalMax) ? total_q : total_q + 31'd1;

  always_comb begin
    for (int i = 0; i < itoa_pkg::BcdDigits; i++) begin
      bcd_adj[4*i +: 4] = (dig_q[4*i +: 4] >= 4'd5) ? dig_q[4*i +: 4] + 4'd3
                                                   : dig_q[4*i +: 4];
    end
  end

  always_comb begin
    lead_pos = '0;
    for (int i = 0; i < itoa_pkg::NumNibs; i++) begin
      if (dig_q[4*i +: 4] != 4'd0) lead_pos = itoa_pkg::PosWidth'(i);
    end
  end

  always_comb begin
    case (cmd_i.sel)
      itoa_pkg::SEL_MINUS: cur_char = itoa_pkg::CharMinus;
      itoa_pkg::SEL_ZERO:  cur_char = itoa_pkg::CharZero;
      itoa_pkg::SEL_X:     cur_char = itoa_pkg::CharX;
      default: cur_char = itoa_pkg::digit_char(cur_nib, mode_q == itoa_pkg::MODE_HEXU);
    endcase
  end

  always_comb begin
    mode_d      = mode_q;
    neg_d       = neg_q;
    bin_d       = bin_q;
    dig_d       = dig_q;
    step_d      = step_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    total_d     = total_q;

    if (cmd_i.load) begin
      mode_d = in_data_i.mode;
      neg_d  = low_neg;
      step_d = '0;
      bin_d  = low_neg ? (~low + 32'd1) : low;
      if (in_data_i.mode == itoa_pkg::MODE_PTR) begin
        dig_d = in_data_i.operand_value & itoa_pkg::PtrMask;
      end else if (in_data_i.mode == itoa_pkg::MODE_SDEC ||
                   in_data_i.mode == itoa_pkg::MODE_UDEC) begin
        dig_d = '0;
      end else begin
        dig_d = {32'd0, low};
      end
    end

    if (cmd_i.conv_step) begin
      dig_d  = {{(4*itoa_pkg::NumNibs-itoa_pkg::BcdBits){1'b0}},
                bcd_adj[itoa_pkg::BcdBits-2:0], bin_q[itoa_pkg::DecBits-1]};
      bin_d  = {bin_q[itoa_pkg::DecBits-2:0], 1'b0};
      step_d = step_q + 1'b1;
    end

    if (cmd_i.lead) begin
      pos_d = lead_pos;
    end

    if (cmd_i.emit) begin
      out_valid_d            = 1'b1;
      out_data_d.out_char    = cur_char;
      out_data_d.last_char   = cmd_i.last;
      out_data_d.count_after = total_inc;
      total_d                = total_inc;
      if (cmd_i.sel == itoa_pkg::SEL_DIGIT) pos_d = pos_q - 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      total_q     <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      total_q     <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    neg_q      <= neg_d;
    bin_q      <= bin_d;
    dig_q      <= dig_d;
    step_q     <= step_d;
    pos_q      <= pos_d;
    out_data_q <= out_data_d;
  end

  assign sts_o.is_ptr    = (mode_q == itoa_pkg::MODE_PTR);
  assign sts_o.neg       = neg_q;
  assign sts_o.step_last = (step_q == itoa_pkg::StepWidth'(itoa_pkg::DecBits - 1));
  assign sts_o.pos_zero  = (pos_q == '0);
  assign sts_o.out_free  = out_free;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### rtl/core/integer_to_ascii_formatter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer to ASCII formatter
// Formats one number per input beat as ASCII text, one character per output
// beat, most significant character first, with the final character flagged.
// The input beat carries a mode and a 64-bit operand; the output beat carries
// the character, the last flag and a saturating running character count.
// Decimal modes run a 32-step shift-add-3 conversion before the first
// character appears; hex modes skip the conversion. Characters then leave
// one per cycle while the receiver is ready, from a single output register.
// A new input beat is taken as soon as the last character sits in the output
// register, even while it waits to be taken. Undefined modes are accepted
// and produce no output. When the receiver stalls, the pending character is
// held and emission pauses. Reset empties the output register, returns the
// controller to idle and clears the running count.
// ----------------------------------------------------------------------------
`include "integer_to_ascii_formatter_top_defines.svh"

module integer_to_ascii_formatter_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  itoa_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output itoa_pkg::out_beat_t out_data_o
);

  itoa_pkg::cmd_t cmd;
  itoa_pkg::sts_t sts;

  itoa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (in_data_i.mode),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  itoa_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  `ITOA_ASSERT(a_emit_needs_room, clk_i, rst_ni, cmd.emit |-> sts.out_free, "Output is full.")
  `ITOA_ASSERT(a_emit_shows_beat, clk_i, rst_ni, cmd.emit |=> out_valid_o, "Beat not shown.")
  `ITOA_ASSERT_NEVER(a_ready_while_emit, clk_i, rst_ni, in_ready_o && cmd.emit, "Ready in emit.")

endmodule
